>>> rtl/msrc_pkg.sv
`default_nettype none

package msrc_pkg;

  // Operating modes
  localparam logic [1:0] MODE_STOPPED  = 2'd0;
  localparam logic [1:0] MODE_PRESTART = 2'd1;
  localparam logic [1:0] MODE_RUNNING  = 2'd2;
  localparam logic [1:0] MODE_FAULT    = 2'd3;

  // Event codes
  localparam int unsigned ACT_W = 3;
  localparam logic [ACT_W-1:0] ACT_TICK        = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START       = 3'd1;
  localparam logic [ACT_W-1:0] ACT_STOP        = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SET_TARGET  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FAULT       = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RESET_FAULT = 3'd5;
  localparam logic [ACT_W-1:0] ACT_ILOCK_CLOSE = 3'd6;
  localparam logic [ACT_W-1:0] ACT_ILOCK_OPEN  = 3'd7;

  // Config register indexes
  localparam int unsigned CFG_AW = 2;
  localparam logic [CFG_AW-1:0] CFG_RAMP_INTERVAL = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_START_DELAY   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_BASE_SPEED    = 2'd2;

  // Reset values
  localparam longint RAMP_INTERVAL_RST = 80;
  localparam longint START_DELAY_RST   = 10000;
  localparam longint BASE_SPEED_RST    = 10;

  typedef struct packed {
    logic [1:0] mode;
    logic       fault_active;
    logic       interlock_state;
    logic       mode_changed;
    logic       speed_reported;
  } msrc_flags_t;

endpackage

`default_nettype wire

>>> rtl/msrc_if.sv
`default_nettype none

interface msrc_in_if #(
  parameter int SPEED_WIDTH = 12
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             action;
  logic [SPEED_WIDTH-1:0] target_speed;

  modport source (output valid, action, target_speed, input ready);
  modport sink   (input valid, action, target_speed, output ready);
endinterface

interface msrc_out_if #(
  parameter int SPEED_WIDTH = 12
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic [SPEED_WIDTH-1:0] current_speed;
  logic                   fault_active;
  logic                   interlock_state;
  logic                   mode_changed;
  logic                   speed_reported;

  modport source (output valid, mode, current_speed, fault_active, interlock_state,
                  mode_changed, speed_reported, input ready);
  modport sink   (input valid, mode, current_speed, fault_active, interlock_state,
                  mode_changed, speed_reported, output ready);
endinterface

`default_nettype wire

>>> rtl/msrc_cfg.sv
`default_nettype none

module msrc_cfg
  import msrc_pkg::*;
#(
  parameter int SPEED_WIDTH = 12,
  parameter int TIMER_WIDTH = 16,
  parameter int CFG_DW      = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   we,
  input  logic [CFG_AW-1:0]      index,
  input  logic [CFG_DW-1:0]      wdata,
  output logic [TIMER_WIDTH-1:0] ramp_interval,
  output logic [TIMER_WIDTH-1:0] start_delay,
  output logic [SPEED_WIDTH-1:0] base_speed
);

  localparam longint SPEED_MAX = (longint'(1) << SPEED_WIDTH) - 1;
  localparam logic [SPEED_WIDTH-1:0] BASE_RST =
    (BASE_SPEED_RST > SPEED_MAX) ? '1 : SPEED_WIDTH'(BASE_SPEED_RST);

  logic [TIMER_WIDTH-1:0] ramp_interval_r;
  logic [TIMER_WIDTH-1:0] start_delay_r;
  logic [SPEED_WIDTH-1:0] base_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_interval_r <= TIMER_WIDTH'(RAMP_INTERVAL_RST);
      start_delay_r   <= TIMER_WIDTH'(START_DELAY_RST);
      base_speed_r    <= BASE_RST;
    end else if (we) begin
      case (index)
        CFG_RAMP_INTERVAL: ramp_interval_r <= wdata[TIMER_WIDTH-1:0];
        CFG_START_DELAY:   start_delay_r   <= wdata[TIMER_WIDTH-1:0];
        CFG_BASE_SPEED:    base_speed_r    <= wdata[SPEED_WIDTH-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign ramp_interval = ramp_interval_r;
  assign start_delay   = start_delay_r;
  assign base_speed    = base_speed_r;

endmodule

`default_nettype wire

>>> rtl/msrc_stage.sv
`default_nettype none

// Full-rate valid/ready register slice.
module msrc_stage #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         valid_r;
  logic [W-1:0] data_r;

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

>>> rtl/msrc_core.sv
`default_nettype none

module msrc_core
  import msrc_pkg::*;
#(
  parameter int SPEED_WIDTH = 12,
  parameter int TIMER_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [ACT_W-1:0]       action,
  input  logic [SPEED_WIDTH-1:0] target_speed,
  input  logic [TIMER_WIDTH-1:0] ramp_interval,
  input  logic [TIMER_WIDTH-1:0] start_delay,
  input  logic [SPEED_WIDTH-1:0] base_speed,
  output logic [SPEED_WIDTH-1:0] res_speed,
  output msrc_flags_t            res_flags
);

  localparam longint SPEED_MAX = (longint'(1) << SPEED_WIDTH) - 1;
  localparam logic [SPEED_WIDTH-1:0] SPEED_RST =
    (BASE_SPEED_RST > SPEED_MAX) ? '1 : SPEED_WIDTH'(BASE_SPEED_RST);

  logic [1:0]             mode_r,  mode_nxt;
  logic [SPEED_WIDTH-1:0] speed_r, speed_nxt;
  logic [SPEED_WIDTH-1:0] goal_r,  goal_nxt;
  logic                   fault_r, fault_nxt;
  logic                   ilock_r, ilock_nxt;
  logic [TIMER_WIDTH-1:0] phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] cdown_r, cdown_nxt;
  logic                   mchg, spd;

  // Tick path: delay countdown first, then the ramp timer
  logic [TIMER_WIDTH-1:0] cdown_dec;
  logic                   expire;
  logic [1:0]             mode_tick;
  logic [SPEED_WIDTH-1:0] speed_tick, goal_tick, speed_ramp;
  logic [TIMER_WIDTH-1:0] phase_inc;
  logic                   fire;

  assign cdown_dec  = (cdown_r != '0) ? cdown_r - TIMER_WIDTH'(1) : cdown_r;
  assign expire     = (mode_r == MODE_PRESTART) && (cdown_dec == '0);
  assign mode_tick  = expire ? MODE_RUNNING : mode_r;
  assign speed_tick = expire ? base_speed : speed_r;
  assign goal_tick  = expire ? base_speed : goal_r;

  // interval of zero behaves as one: compare >= 0 always fires
  assign phase_inc  = phase_r + TIMER_WIDTH'(1);
  assign fire       = (phase_inc >= ramp_interval) || (phase_inc == '0);

  assign speed_ramp = (speed_tick < goal_tick) ? speed_tick + SPEED_WIDTH'(1) :
                      (speed_tick > goal_tick) ? speed_tick - SPEED_WIDTH'(1) : speed_tick;

  always_comb begin
    mode_nxt  = mode_r;
    speed_nxt = speed_r;
    goal_nxt  = goal_r;
    fault_nxt = fault_r;
    ilock_nxt = ilock_r;
    phase_nxt = phase_r;
    cdown_nxt = cdown_r;
    mchg      = 1'b0;
    spd       = 1'b0;
    case (action)
      ACT_TICK: begin
        mode_nxt  = mode_tick;
        speed_nxt = speed_tick;
        goal_nxt  = goal_tick;
        if (mode_r == MODE_PRESTART) begin
          cdown_nxt = cdown_dec;
        end
        mchg      = expire;
        spd       = expire;
        phase_nxt = fire ? '0 : phase_inc;
        if (fire && (mode_tick == MODE_RUNNING)) begin
          speed_nxt = speed_ramp;
          spd       = 1'b1;
        end
      end
      ACT_START: begin
        if (!fault_r && (mode_r == MODE_STOPPED)) begin
          mode_nxt  = MODE_PRESTART;
          cdown_nxt = (start_delay == '0) ? TIMER_WIDTH'(1) : start_delay;
          mchg      = 1'b1;
        end
      end
      ACT_STOP: begin
        if (!fault_r) begin
          mode_nxt  = MODE_STOPPED;
          cdown_nxt = '0;
          speed_nxt = base_speed;
          goal_nxt  = base_speed;
          mchg      = 1'b1;
          spd       = 1'b1;
        end
      end
      ACT_SET_TARGET: begin
        goal_nxt = target_speed;
      end
      ACT_FAULT: begin
        mode_nxt  = MODE_FAULT;
        fault_nxt = 1'b1;
        cdown_nxt = '0;
        speed_nxt = base_speed;
        goal_nxt  = base_speed;
        mchg      = 1'b1;
        spd       = 1'b1;
      end
      ACT_RESET_FAULT: begin
        if (!ilock_r) begin
          mode_nxt  = MODE_STOPPED;
          fault_nxt = 1'b0;
          cdown_nxt = '0;
          mchg      = 1'b1;
        end
      end
      ACT_ILOCK_CLOSE: ilock_nxt = 1'b1;
      ACT_ILOCK_OPEN:  ilock_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_STOPPED;
      speed_r <= SPEED_RST;
      goal_r  <= SPEED_RST;
      fault_r <= 1'b0;
      ilock_r <= 1'b0;
      phase_r <= '0;
      cdown_r <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      speed_r <= speed_nxt;
      goal_r  <= goal_nxt;
      fault_r <= fault_nxt;
      ilock_r <= ilock_nxt;
      phase_r <= phase_nxt;
      cdown_r <= cdown_nxt;
    end
  end

  assign res_speed                 = speed_nxt;
  assign res_flags.mode            = mode_nxt;
  assign res_flags.fault_active    = fault_nxt;
  assign res_flags.interlock_state = ilock_nxt;
  assign res_flags.mode_changed    = mchg;
  assign res_flags.speed_reported  = spd;

endmodule

`default_nettype wire

>>> rtl/motor_start_ramp_controller.sv
// Path: an input transfer goes through the input register, then the result register
//   written by the mode/speed update, to out_ch. Throughput: one event per cycle
//   while out_ch accepts; the state update is a single compare/increment pass.
// Reset: rst_n synchronous, active low. Mode stopped, speed and target 10, latches and
//   timers clear, config back to ramp_interval 80, start_delay 10000, base_speed 10.
`default_nettype none

module motor_start_ramp_controller
  import msrc_pkg::*;
#(
  parameter int SPEED_WIDTH = 12,
  parameter int TIMER_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  msrc_in_if.sink          in_ch,
  msrc_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [((TIMER_WIDTH > SPEED_WIDTH) ? TIMER_WIDTH : SPEED_WIDTH)-1:0] cfg_wdata
);

  localparam int CFG_DW = (TIMER_WIDTH > SPEED_WIDTH) ? TIMER_WIDTH : SPEED_WIDTH;
  localparam int IN_W   = ACT_W + SPEED_WIDTH;
  localparam int OUT_W  = SPEED_WIDTH + $bits(msrc_flags_t);

  // ---------------------------------------------------------------------------
  // Configuration registers. User writes only while the block is quiet (not enforced).
  // ---------------------------------------------------------------------------
  logic [TIMER_WIDTH-1:0] ramp_interval;
  logic [TIMER_WIDTH-1:0] start_delay;
  logic [SPEED_WIDTH-1:0] base_speed;

  msrc_cfg #(
    .SPEED_WIDTH (SPEED_WIDTH),
    .TIMER_WIDTH (TIMER_WIDTH),
    .CFG_DW      (CFG_DW)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .we            (cfg_we),
    .index         (cfg_index),
    .wdata         (cfg_wdata),
    .ramp_interval (ramp_interval),
    .start_delay   (start_delay),
    .base_speed    (base_speed)
  );

  // ---------------------------------------------------------------------------
  // Input register: event code and target, captured on each in_ch transfer.
  // ---------------------------------------------------------------------------
  logic                   ev_valid;
  logic                   ev_ready;
  logic [IN_W-1:0]        ev_data;
  logic [ACT_W-1:0]       ev_action;
  logic [SPEED_WIDTH-1:0] ev_target;

  msrc_stage #(.W(IN_W)) u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   ({in_ch.action, in_ch.target_speed}),
    .out_valid (ev_valid),
    .out_ready (ev_ready),
    .out_data  (ev_data)
  );

  assign ev_action = ev_data[IN_W-1 -: ACT_W];
  assign ev_target = ev_data[SPEED_WIDTH-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer state. The state commits on the same edge the result is
  // written to the output register, so each event sees the previous one's
  // state even when events arrive every cycle.
  // ---------------------------------------------------------------------------
  logic                   step;
  logic [SPEED_WIDTH-1:0] res_speed;
  msrc_flags_t            res_flags;

  assign step = ev_valid && ev_ready;

  msrc_core #(
    .SPEED_WIDTH (SPEED_WIDTH),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .action        (ev_action),
    .target_speed  (ev_target),
    .ramp_interval (ramp_interval),
    .start_delay   (start_delay),
    .base_speed    (base_speed),
    .res_speed     (res_speed),
    .res_flags     (res_flags)
  );

  // ---------------------------------------------------------------------------
  // Result register. Holds a finished result while out_ch is stalled; the input
  // register can still take one more event, then in_ch stalls as well.
  // ---------------------------------------------------------------------------
  logic [OUT_W-1:0] out_data;
  msrc_flags_t      out_flags;

  msrc_stage #(.W(OUT_W)) u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ev_valid),
    .in_ready  (ev_ready),
    .in_data   ({res_speed, res_flags}),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_flags              = out_data[$bits(msrc_flags_t)-1:0];
  assign out_ch.current_speed   = out_data[OUT_W-1 -: SPEED_WIDTH];
  assign out_ch.mode            = out_flags.mode;
  assign out_ch.fault_active    = out_flags.fault_active;
  assign out_ch.interlock_state = out_flags.interlock_state;
  assign out_ch.mode_changed    = out_flags.mode_changed;
  assign out_ch.speed_reported  = out_flags.speed_reported;

endmodule

`default_nettype wire

>>> rtl/msrc_checker.sv
`default_nettype none

module msrc_checker
  import msrc_pkg::*;
#(
  parameter int SPEED_WIDTH = 12
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [1:0]             mode,
  input wire logic [SPEED_WIDTH-1:0] current_speed,
  input wire logic                   fault_active,
  input wire logic                   mode_changed,
  input wire logic                   speed_reported
);

  logic                   seen_r;
  logic [1:0]             pmode_r;
  logic [SPEED_WIDTH-1:0] pspeed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      pmode_r  <= mode;
      pspeed_r <= current_speed;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(current_speed))
    else $error("result changed while stalled");

  // fault latch and fault mode go together
  a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (fault_active == (mode == MODE_FAULT)))
    else $error("fault latch and mode disagree");

  // mode moves only with a change flag
  a_mode_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && seen_r && !mode_changed |-> mode == pmode_r)
    else $error("mode changed without mode_changed");

  // speed moves only with a speed report
  a_speed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && seen_r && !speed_reported |-> current_speed == pspeed_r)
    else $error("speed changed without speed_reported");

endmodule

bind motor_start_ramp_controller msrc_checker #(.SPEED_WIDTH(SPEED_WIDTH)) u_msrc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .mode           (out_ch.mode),
  .current_speed  (out_ch.current_speed),
  .fault_active   (out_ch.fault_active),
  .mode_changed   (out_ch.mode_changed),
  .speed_reported (out_ch.speed_reported)
);

`default_nettype wire

>>> sim/motor_start_ramp_controller_test.sv
`timescale 1ns / 100ps

module motor_start_ramp_controller_test;
  import msrc_pkg::*;

  localparam int SPEED_W = 12;
  localparam int TIMER_W = 16;
  // Index 3 decodes to no register; a write there must leave everything alone.
  localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;
  // Quiet cycles allowed with no transfer on either channel. The slow stretches
  // are the long receiver hold and long idle runs at 81 percent.
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 40;
  localparam int NUM_PHASES = 8;

  // One status word as the block reports it after an event.
  typedef struct packed {
    logic [1:0]         mode;
    logic [SPEED_W-1:0] current_speed;
    logic               fault_active;
    logic               interlock_state;
    logic               mode_changed;
    logic               speed_reported;
  } motor_status_t;

  // Shadow of the sequencer: keeps its own mode, speeds, timers and register
  // copies, and queues the status each accepted event should produce.
  class motor_status_tracker;
    logic [TIMER_W-1:0] ramp_ivl;
    logic [TIMER_W-1:0] start_dly;
    logic [SPEED_W-1:0] base_spd;
    logic [1:0]         mode;
    logic [SPEED_W-1:0] speed;
    logic [SPEED_W-1:0] goal;
    logic               fault_on;
    logic               ilock_on;
    logic [TIMER_W-1:0] ramp_ph;
    logic [TIMER_W-1:0] start_cnt;
    motor_status_t      status_due[$];
    int                 fail_count;
    int                 checked;

    function new();
      ramp_ivl   = TIMER_W'(RAMP_INTERVAL_RST);
      start_dly  = TIMER_W'(START_DELAY_RST);
      base_spd   = SPEED_W'(BASE_SPEED_RST);
      mode       = MODE_STOPPED;
      speed      = SPEED_W'(BASE_SPEED_RST);
      goal       = SPEED_W'(BASE_SPEED_RST);
      fault_on   = 1'b0;
      ilock_on   = 1'b0;
      ramp_ph    = '0;
      start_cnt  = '0;
      fail_count = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [TIMER_W-1:0] val);
      case (idx)
        CFG_RAMP_INTERVAL: ramp_ivl = val;
        CFG_START_DELAY:   start_dly = val;
        CFG_BASE_SPEED:    base_spd = val[SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    function motor_status_t advance(logic [ACT_W-1:0] act, logic [SPEED_W-1:0] tgt);
      motor_status_t      res;
      logic [TIMER_W-1:0] lim;
      res = '0;
      case (act)
        ACT_TICK: begin
          // delay expiry first, then the ramp timer on the same tick
          if (mode == MODE_PRESTART) begin
            if (start_cnt != 0) start_cnt = start_cnt - TIMER_W'(1);
            if (start_cnt == 0) begin
              mode = MODE_RUNNING;
              speed = base_spd;
              goal = base_spd;
              res.mode_changed = 1'b1;
              res.speed_reported = 1'b1;
            end
          end
          lim = (ramp_ivl == 0) ? TIMER_W'(1) : ramp_ivl;
          ramp_ph = ramp_ph + TIMER_W'(1);
          if (ramp_ph >= lim || ramp_ph == 0) begin
            ramp_ph = '0;
            if (mode == MODE_RUNNING) begin
              if (speed < goal) speed = speed + SPEED_W'(1);
              else if (speed > goal) speed = speed - SPEED_W'(1);
              res.speed_reported = 1'b1;
            end
          end
        end
        ACT_START: begin
          if (!fault_on && mode == MODE_STOPPED) begin
            mode = MODE_PRESTART;
            start_cnt = (start_dly == 0) ? TIMER_W'(1) : start_dly;
            res.mode_changed = 1'b1;
          end
        end
        ACT_STOP: begin
          if (!fault_on) begin
            start_cnt = '0;
            mode = MODE_STOPPED;
            speed = base_spd;
            goal = base_spd;
            res.mode_changed = 1'b1;
            res.speed_reported = 1'b1;
          end
        end
        ACT_SET_TARGET: goal = tgt;
        ACT_FAULT: begin
          start_cnt = '0;
          fault_on = 1'b1;
          mode = MODE_FAULT;
          speed = base_spd;
          goal = base_spd;
          res.mode_changed = 1'b1;
          res.speed_reported = 1'b1;
        end
        ACT_RESET_FAULT: begin
          // speeds are kept; refused while the interlock is closed
          if (!ilock_on) begin
            fault_on = 1'b0;
            mode = MODE_STOPPED;
            start_cnt = '0;
            res.mode_changed = 1'b1;
          end
        end
        ACT_ILOCK_CLOSE: ilock_on = 1'b1;
        default: ilock_on = 1'b0;
      endcase
      res.mode = mode;
      res.current_speed = speed;
      res.fault_active = fault_on;
      res.interlock_state = ilock_on;
      return res;
    endfunction

    function void note_event(logic [ACT_W-1:0] act, logic [SPEED_W-1:0] tgt);
      status_due.push_back(advance(act, tgt));
    endfunction

    task report(string msg);
      fail_count++;
      if (fail_count <= 20) $display("mismatch at result %0d: %s", checked, msg);
    endtask

    task check_status(motor_status_t got);
      motor_status_t want;
      checked++;
      if (status_due.size() == 0) begin
        report("result with nothing pending");
      end else begin
        want = status_due.pop_front();
        if (got.mode !== want.mode)
          report($sformatf("mode %0d, want %0d", got.mode, want.mode));
        if (got.current_speed !== want.current_speed)
          report($sformatf("current_speed %0d, want %0d", got.current_speed,
                           want.current_speed));
        if (got.fault_active !== want.fault_active)
          report($sformatf("fault_active %b, want %b", got.fault_active, want.fault_active));
        if (got.interlock_state !== want.interlock_state)
          report($sformatf("interlock_state %b, want %b", got.interlock_state,
                           want.interlock_state));
        if (got.mode_changed !== want.mode_changed)
          report($sformatf("mode_changed %b, want %b", got.mode_changed, want.mode_changed));
        if (got.speed_reported !== want.speed_reported)
          report($sformatf("speed_reported %b, want %b", got.speed_reported,
                           want.speed_reported));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_AW-1:0]  cfg_index;
  logic [TIMER_W-1:0] cfg_wdata;

  msrc_in_if  #(.SPEED_WIDTH(SPEED_W)) in_ch ();
  msrc_out_if #(.SPEED_WIDTH(SPEED_W)) out_ch ();

  motor_start_ramp_controller #(
    .SPEED_WIDTH(SPEED_W),
    .TIMER_WIDTH(TIMER_W)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  motor_status_tracker tracker;

  // Idle odds in percent for each side; changed per block of phases.
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  // Long receiver hold: main flips hold_tog (nonblocking), the receiver
  // process notices the flip and counts hold_left down from hold_len on its own.
  logic          hold_tog;
  int            hold_len;
  logic          hold_seen;
  int            hold_left;
  motor_status_t seen_status;
  int            quiet_cycles;
  int            sent_count;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result side: check every transfer, then pick ready for the next edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_status.mode            = out_ch.mode;
      seen_status.current_speed   = out_ch.current_speed;
      seen_status.fault_active    = out_ch.fault_active;
      seen_status.interlock_state = out_ch.interlock_state;
      seen_status.mode_changed    = out_ch.mode_changed;
      seen_status.speed_reported  = out_ch.speed_reported;
      tracker.check_status(seen_status);
    end
    if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: too long without any transfer means the block is hung.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("motor_start_ramp_controller verification failed");
      $finish;
    end
  end

  // Offer one event, with random idle cycles ahead of it, and log it with
  // the tracker at the edge where it transfers. valid stays high on return so
  // back-to-back events need no extra drive.
  task automatic send_event(input logic [ACT_W-1:0] act, input logic [SPEED_W-1:0] tgt);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.target_speed <= tgt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_event(act, tgt);
    sent_count++;
  endtask

  // Register write; cfg_we is left high so writes can run back to back.
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [TIMER_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic configure(input logic [TIMER_W-1:0] ivl, input logic [TIMER_W-1:0] dly,
                           input logic [TIMER_W-1:0] base);
    write_reg(CFG_RAMP_INTERVAL, ivl);
    write_reg(CFG_START_DELAY, dly);
    write_reg(CFG_BASE_SPEED, base);
    cfg_we <= 1'b0;
  endtask

  // Stop offering and wait for every pending status to come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.status_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int               p;
    int               phase_start;
    int               n;
    int               k;
    bit               held;
    bit               paused;
    logic [TIMER_W-1:0] ivl;
    logic [TIMER_W-1:0] dly;
    logic [TIMER_W-1:0] base;

    tracker            = new();
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_TICK;
    in_ch.target_speed = '0;
    out_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_RAMP_INTERVAL;
    cfg_wdata          = '0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    hold_tog           = 1'b0;
    hold_seen          = 1'b0;
    hold_len           = 0;
    hold_left          = 0;
    quiet_cycles       = 0;
    sent_count         = 0;
    held               = 1'b0;
    paused             = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short interval and delay so running is reached quickly, base
    // at full scale so the ramp can walk down from the top.
    configure(16'd2, 16'd3, 16'd4095);
    send_event(ACT_TICK, 12'd0);
    send_event(ACT_START, 12'hFFF);
    send_event(ACT_TICK, 12'd0);
    send_event(ACT_TICK, 12'd0);
    send_event(ACT_TICK, 12'd0);          // delay runs out, ramp fires on same tick
    send_event(ACT_SET_TARGET, 12'd0);
    send_event(ACT_TICK, 12'hFFF);
    send_event(ACT_TICK, 12'hFFF);        // step down one
    send_event(ACT_SET_TARGET, 12'hFFF);
    send_event(ACT_TICK, 12'd0);
    send_event(ACT_TICK, 12'd0);          // back up to full scale
    send_event(ACT_TICK, 12'd0);
    send_event(ACT_TICK, 12'd0);          // fires with speed already at target
    send_event(ACT_START, 12'd0);         // start while running: no effect
    send_event(ACT_STOP, 12'd0);
    send_event(ACT_FAULT, 12'd0);
    send_event(ACT_FAULT, 12'd0);         // fault while already faulted
    send_event(ACT_START, 12'd0);         // ignored while faulted
    send_event(ACT_STOP, 12'd0);          // ignored while faulted
    send_event(ACT_ILOCK_CLOSE, 12'd0);
    send_event(ACT_RESET_FAULT, 12'd0);   // refused, interlock closed
    send_event(ACT_ILOCK_OPEN, 12'd0);
    send_event(ACT_RESET_FAULT, 12'd0);
    send_event(ACT_RESET_FAULT, 12'd0);   // no fault latched, still taken
    send_event(ACT_START, 12'd0);
    send_event(ACT_FAULT, 12'd0);         // fault during pre-start
    drain();

    // Random phases, each with its own register setting. The long-interval
    // phase leaves the ramp timer far along, so the next phase lowers the
    // interval below the running count.
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin ivl = 16'hFFFF; dly = 16'hFFFF; base = 16'($urandom_range(0, 4095)); end
        1: begin ivl = 16'd3; dly = 16'd4; base = 16'd0; end
        2: begin ivl = 16'd0; dly = 16'd0; base = 16'd4095; end
        3: begin ivl = 16'd1; dly = 16'd1; base = 16'($urandom_range(0, 4095)); end
        4: begin
          ivl = 16'($urandom_range(1, 6));
          dly = 16'($urandom_range(1, 8));
          base = 16'($urandom_range(0, 65535));   // upper data bits are dropped
        end
        5: begin
          ivl = 16'd2; dly = 16'd2; base = 16'($urandom_range(0, 4095));
          write_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
        end
        6: begin
          ivl = 16'($urandom_range(1, 4));
          dly = 16'($urandom_range(1, 5));
          base = 16'($urandom_range(0, 4095));
        end
        default: begin ivl = 16'd5; dly = 16'd3; base = 16'd2048; end
      endcase
      configure(ivl, dly, base);

      if (p < 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 81;
      end else if (p < 6) begin
        send_idle_pct = 81;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      phase_start = sent_count;
      while (sent_count - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          // Well-formed run: open the interlock, clear any fault, start, tick, set a
          // fresh target and tick on to ramp toward it, then maybe stop or fault.
          send_event(ACT_ILOCK_OPEN, SPEED_W'($urandom_range(0, 4095)));
          send_event(ACT_RESET_FAULT, SPEED_W'($urandom_range(0, 4095)));
          send_event(ACT_START, SPEED_W'($urandom_range(0, 4095)));
          n = $urandom_range(1, 10);
          repeat (n) send_event(ACT_TICK, SPEED_W'($urandom_range(0, 4095)));
          send_event(ACT_SET_TARGET, SPEED_W'($urandom_range(0, 4095)));
          n = $urandom_range(2, 14);
          repeat (n) send_event(ACT_TICK, SPEED_W'($urandom_range(0, 4095)));
          k = $urandom_range(0, 3);
          if (k == 0) send_event(ACT_STOP, SPEED_W'($urandom_range(0, 4095)));
          else if (k == 1) send_event(ACT_FAULT, SPEED_W'($urandom_range(0, 4095)));
        end else begin
          // Noise: any event, any target.
          n = $urandom_range(1, 6);
          repeat (n) send_event(ACT_W'($urandom_range(0, 7)),
                                SPEED_W'($urandom_range(0, 4095)));
        end

        // Back-pressure: receiver stalls for a long stretch while events keep
        // coming, so the pipeline fills and the input side stops taking them.
        if (p == 6 && !held && sent_count - phase_start >= 8) begin
          held = 1'b1;
          hold_len <= 60;
          hold_tog <= ~hold_tog;
        end
        // Sender pause mid-phase until everything pending has come back.
        if (p == 7 && !paused && sent_count - phase_start >= 20) begin
          paused = 1'b1;
          drain();
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (tracker.fail_count == 0) begin
      $display("motor_start_ramp_controller verification clean");
    end else begin
      $display("motor_start_ramp_controller verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/msrc_pkg.sv
rtl/msrc_if.sv
rtl/msrc_cfg.sv
rtl/msrc_stage.sv
rtl/msrc_core.sv
rtl/motor_start_ramp_controller.sv
rtl/msrc_checker.sv
sim/motor_start_ramp_controller_test.sv
